FILE: rtl/lr_pkg.sv
// Shared types and constants of the line rasterizer.
// Holds the beat structs, the command and status structs and the state enums.
// Depends on nothing.
package lr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int PIXEL_W        = 16;
  localparam int INTENSITY_W    = 8;
  localparam int FRAC_BITS      = 16;
  localparam int DIV_CNT_W      = $clog2(FRAC_BITS + 1);

  localparam logic [INTENSITY_W-1:0] INTENSITY_FULL = 8'hFF;

  typedef enum logic {
    KIND_LOAD,
    KIND_STEP
  } lr_kind_e;

  typedef enum logic [1:0] {
    MODE_AXIS,
    MODE_MONO,
    MODE_AA
  } lr_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_START,
    ST_DIV,
    ST_SECOND
  } lr_state_e;

  typedef struct packed {
    lr_kind_e                   kind;
    logic signed [PIXEL_W-1:0]  start_x;
    logic signed [PIXEL_W-1:0]  start_y;
    logic signed [PIXEL_W-1:0]  end_x;
    logic signed [PIXEL_W-1:0]  end_y;
  } lr_in_t;

  typedef struct packed {
    logic signed [PIXEL_W-1:0]  pixel_x;
    logic signed [PIXEL_W-1:0]  pixel_y;
    logic [INTENSITY_W-1:0]     intensity;
    logic                       last_of_item;
    logic                       line_done;
  } lr_out_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic div_start;
    logic second;
  } lr_cmd_t;

  typedef struct packed {
    logic is_load;
    logic active;
    logic aa_pair;
    logic need_div;
    logic div_busy;
    logic slot_free;
  } lr_stat_t;

endpackage

FILE: rtl/lr_div.sv
// Iterative restoring divider for the anti-aliasing slope, one quotient bit per cycle.
// Computes (minor << FRAC_BITS) / count for minor <= count.
// Depends on lr_pkg.
module lr_div
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] minor_i,
  input  logic [COORD_BITS-1:0] count_i,
  output logic                  busy_o,
  output logic [FRAC_BITS:0]    quot_o
);

  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [FRAC_BITS:0]    quot_q, quot_d;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   divisor;
  logic                  ge;

  always_comb begin
    divisor = {1'b0, count_i};
    trial   = (cnt_q == '0) ? rem_q : {rem_q[COORD_BITS-1:0], 1'b0};
    ge      = (trial >= divisor);
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, minor_i};
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (trial - divisor) : trial;
      quot_d = {quot_q[FRAC_BITS-1:0], ge};
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(FRAC_BITS)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/lr_dpath.sv
// Datapath of the line rasterizer: line state, stepping arithmetic and output register.
// Acts on commands from lr_ctrl and reports status back; holds the slope divider.
// Depends on lr_pkg and lr_div.
module lr_dpath
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lr_cmd_t  cmd_i,
  output lr_stat_t stat_o,
  input  lr_in_t   in_data_i,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output lr_out_t  out_data_o
);

  localparam int CB = COORD_BITS;

  logic                  antialias_q;
  logic                  aa_cap_q;
  logic                  active_q, active_d;
  lr_mode_e              mode_q;
  logic [CB-1:0]         cur_col_q, cur_col_d;
  logic [CB-1:0]         cur_row_q, cur_row_d;
  logic [CB-1:0]         tgt_col_q, tgt_row_q;
  logic [CB-1:0]         dcol_q, drow_q;
  logic                  neg_col_q, neg_row_q, col_major_q;
  logic signed [CB+1:0]  err_q, err_d;
  logic [FRAC_BITS-1:0]  frac_q, frac_d;
  logic [CB-1:0]         steps_q, steps_d;
  logic                  out_valid_q, out_valid_d;
  lr_out_t               out_q, out_d;

  logic [CB-1:0]         in_x0, in_y0, in_x1, in_y1;
  logic                  in_point;

  logic signed [CB:0]    s_dx, s_dy;
  logic [CB-1:0]         s_dcol, s_drow;
  logic                  s_col_major;
  logic signed [CB+1:0]  s_err;
  lr_mode_e              s_mode;

  logic [CB-1:0]         div_count, div_minor;
  logic                  div_busy;
  logic [FRAC_BITS:0]    slope;

  logic [CB-1:0]         col_inc, row_inc;
  logic [FRAC_BITS:0]    frac_sum;
  logic                  carry;
  logic signed [CB+2:0]  e2, neg_dr, pos_dc, err_wide;
  logic                  c1, c2;
  logic [CB-1:0]         new_col, new_row;
  logic                  new_done;
  logic                  slot_free;
  logic                  emit;

  assign in_x0    = in_data_i.start_x[CB-1:0];
  assign in_y0    = in_data_i.start_y[CB-1:0];
  assign in_x1    = in_data_i.end_x[CB-1:0];
  assign in_y1    = in_data_i.end_y[CB-1:0];
  assign in_point = (in_x0 == in_x1) && (in_y0 == in_y1);

  // Setup works on the freshly captured end points in cur and tgt.
  always_comb begin
    s_dx        = $signed({tgt_col_q[CB-1], tgt_col_q}) - $signed({cur_col_q[CB-1], cur_col_q});
    s_dy        = $signed({tgt_row_q[CB-1], tgt_row_q}) - $signed({cur_row_q[CB-1], cur_row_q});
    s_dcol      = s_dx[CB] ? CB'(-s_dx) : s_dx[CB-1:0];
    s_drow      = s_dy[CB] ? CB'(-s_dy) : s_dy[CB-1:0];
    s_col_major = (s_dcol > s_drow);
    s_err       = $signed({2'b00, s_dcol}) - $signed({2'b00, s_drow});
    if ((cur_col_q == tgt_col_q) || (cur_row_q == tgt_row_q)) begin
      s_mode = MODE_AXIS;
    end else if (aa_cap_q) begin
      s_mode = MODE_AA;
    end else begin
      s_mode = MODE_MONO;
    end
  end

  assign div_count = col_major_q ? dcol_q : drow_q;
  assign div_minor = col_major_q ? drow_q : dcol_q;

  lr_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .minor_i (div_minor),
    .count_i (div_count),
    .busy_o  (div_busy),
    .quot_o  (slope)
  );

  // Stepping arithmetic for one step beat.
  always_comb begin
    col_inc  = neg_col_q ? (cur_col_q - CB'(1)) : (cur_col_q + CB'(1));
    row_inc  = neg_row_q ? (cur_row_q - CB'(1)) : (cur_row_q + CB'(1));
    frac_sum = {1'b0, frac_q} + slope;
    carry    = frac_sum[FRAC_BITS];
    e2       = {err_q, 1'b0};
    neg_dr   = -$signed({3'b000, drow_q});
    pos_dc   = $signed({3'b000, dcol_q});
    c1       = (e2 > neg_dr);
    c2       = (e2 < pos_dc);
    err_wide = $signed({err_q[CB+1], err_q}) + (c1 ? neg_dr : '0) + (c2 ? pos_dc : '0);
    case (mode_q)
      MODE_AA: begin
        if (col_major_q) begin
          new_col = col_inc;
          new_row = carry ? row_inc : cur_row_q;
        end else begin
          new_row = row_inc;
          new_col = carry ? col_inc : cur_col_q;
        end
      end
      MODE_MONO: begin
        new_col = c1 ? col_inc : cur_col_q;
        new_row = c2 ? row_inc : cur_row_q;
      end
      default: begin
        new_col = (cur_col_q != tgt_col_q) ? col_inc : cur_col_q;
        new_row = (cur_row_q != tgt_row_q) ? row_inc : cur_row_q;
      end
    endcase
    new_done = (new_col == tgt_col_q) && (new_row == tgt_row_q);
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    active_d  = active_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    err_d     = err_q;
    frac_d    = frac_q;
    steps_d   = steps_q;
    emit      = 1'b0;
    out_d     = out_q;
    if (cmd_i.accept) begin
      if (in_data_i.kind == KIND_LOAD) begin
        emit               = 1'b1;
        active_d           = !in_point;
        cur_col_d          = in_x0;
        cur_row_d          = in_y0;
        out_d.pixel_x      = PIXEL_W'($signed(in_x0));
        out_d.pixel_y      = PIXEL_W'($signed(in_y0));
        out_d.intensity    = INTENSITY_FULL;
        out_d.last_of_item = 1'b1;
        out_d.line_done    = in_point;
      end else if (active_q) begin
        emit = 1'b1;
        if ((mode_q == MODE_AA) && (steps_q == '0)) begin
          active_d           = 1'b0;
          out_d.pixel_x      = PIXEL_W'($signed(tgt_col_q));
          out_d.pixel_y      = PIXEL_W'($signed(tgt_row_q));
          out_d.intensity    = INTENSITY_FULL;
          out_d.last_of_item = 1'b1;
          out_d.line_done    = 1'b1;
        end else if (mode_q == MODE_AA) begin
          cur_col_d          = new_col;
          cur_row_d          = new_row;
          frac_d             = frac_sum[FRAC_BITS-1:0];
          steps_d            = steps_q - CB'(1);
          out_d.pixel_x      = PIXEL_W'($signed(new_col));
          out_d.pixel_y      = PIXEL_W'($signed(new_row));
          out_d.intensity    = ~frac_sum[FRAC_BITS-1:FRAC_BITS-INTENSITY_W];
          out_d.last_of_item = 1'b0;
          out_d.line_done    = 1'b0;
        end else begin
          cur_col_d          = new_col;
          cur_row_d          = new_row;
          active_d           = !new_done;
          if (mode_q == MODE_MONO) begin
            err_d = err_wide[CB+1:0];
          end
          out_d.pixel_x      = PIXEL_W'($signed(new_col));
          out_d.pixel_y      = PIXEL_W'($signed(new_row));
          out_d.intensity    = INTENSITY_FULL;
          out_d.last_of_item = 1'b1;
          out_d.line_done    = new_done;
        end
      end
    end else if (cmd_i.second) begin
      emit               = 1'b1;
      out_d.pixel_x      = PIXEL_W'($signed(col_major_q ? cur_col_q : col_inc));
      out_d.pixel_y      = PIXEL_W'($signed(col_major_q ? row_inc : cur_row_q));
      out_d.intensity    = frac_q[FRAC_BITS-1:FRAC_BITS-INTENSITY_W];
      out_d.last_of_item = 1'b1;
      out_d.line_done    = 1'b0;
    end else if (cmd_i.setup) begin
      err_d   = s_err;
      frac_d  = '0;
      steps_d = '0;
    end else if (cmd_i.div_start) begin
      steps_d = div_count - CB'(1);
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      antialias_q <= 1'b1;
      aa_cap_q    <= 1'b0;
      active_q    <= 1'b0;
      mode_q      <= MODE_AXIS;
      out_valid_q <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      tgt_col_q   <= '0;
      tgt_row_q   <= '0;
      dcol_q      <= '0;
      drow_q      <= '0;
      neg_col_q   <= 1'b0;
      neg_row_q   <= 1'b0;
      col_major_q <= 1'b0;
      err_q       <= '0;
      frac_q      <= '0;
      steps_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        antialias_q <= cfg_data_i;
      end
      if (cmd_i.accept && (in_data_i.kind == KIND_LOAD)) begin
        aa_cap_q  <= antialias_q;
        tgt_col_q <= in_x1;
        tgt_row_q <= in_y1;
      end
      if (cmd_i.setup) begin
        mode_q      <= s_mode;
        dcol_q      <= s_dcol;
        drow_q      <= s_drow;
        neg_col_q   <= s_dx[CB];
        neg_row_q   <= s_dy[CB];
        col_major_q <= s_col_major;
      end
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      err_q       <= err_d;
      frac_q      <= frac_d;
      steps_q     <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    stat_o.is_load   = (in_data_i.kind == KIND_LOAD);
    stat_o.active    = active_q;
    stat_o.aa_pair   = (mode_q == MODE_AA) && (steps_q != '0);
    stat_o.need_div  = (s_mode == MODE_AA);
    stat_o.div_busy  = div_busy;
    stat_o.slot_free = slot_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/lr_ctrl.sv
// Controller of the line rasterizer: sequences loads, slope division and two-beat steps.
// Drives the datapath through lr_cmd_t and reads lr_stat_t.
// Depends on lr_pkg.
module lr_ctrl
  import lr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lr_stat_t stat_i,
  output lr_cmd_t  cmd_o
);

  lr_state_e state_q, state_d;

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = stat_i.slot_free;
        cmd_o.accept = in_valid_i && stat_i.slot_free;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
      end
      ST_SECOND: begin
        cmd_o.second = stat_i.slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          if (stat_i.is_load) begin
            state_d = ST_SETUP;
          end else if (stat_i.active && stat_i.aa_pair) begin
            state_d = ST_SECOND;
          end
        end
      end
      ST_SETUP: begin
        state_d = stat_i.need_div ? ST_DIV_START : ST_IDLE;
      end
      ST_DIV_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_SECOND: begin
        if (stat_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/line_rasterizer.sv
// Line rasterizer top level: joins the controller and the datapath to the ports.
// Depends on lr_pkg, lr_ctrl, lr_dpath and lr_div.
//
// A load beat emits the start pixel at once and then keeps the input closed for
// the setup state. In anti-aliased mode a slope division follows that produces
// one quotient bit per cycle, so an anti-aliased load keeps the input closed
// through setup, divider start, 17 quotient bits and a last check that the
// divider is done. A step beat is handled on acceptance, except an anti-aliased
// step that makes a pixel pair, whose second pixel comes from the second state.
// All pixels leave through a single output register, and a stalled output holds
// the input closed. The antialias_enable register is sampled when a line is
// loaded and is written through the cfg channel, which is always ready.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  lr_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output lr_out_t out_data_o,
  input  logic    cfg_valid_i,
  output logic    cfg_ready_o,
  input  logic    cfg_data_i
);

  lr_cmd_t  cmd;
  lr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lr_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_done |-> out_data_o.last_of_item)
    else $error("line_done beat without last_of_item");

  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.div_busy)
    else $error("input ready while the slope division runs");

  a_load_blocks_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.kind == KIND_LOAD) |=> !in_ready_o)
    else $error("input ready during load setup");

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.second |-> (out_valid_o && !out_data_o.last_of_item && out_ready_i) || !out_valid_o)
    else $error("neighbor pixel issued while the main pixel is stuck");

endmodule

FILE: dv/line_rasterizer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer: queued load and step beats go in,
// and each pixel beat that comes out is checked against a built-in line predictor.
// Depends on lr_pkg and line_rasterizer.
module line_rasterizer_test;
  import lr_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  lr_in_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  lr_out_t out_data_o;
  logic    cfg_valid_i = 1'b0;
  logic    cfg_ready_o;
  logic    cfg_data_i = 1'b0;

  line_rasterizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lr_in_t  queued_beats[$];
  lr_out_t pending_pixels[$];
  int      mismatches = 0;
  int      pixels_seen = 0;
  int      hold_left = 0;

  // Copy of the line state that the block keeps.
  bit                 aa_cfg = 1'b1;
  bit                 line_active = 1'b0;
  lr_mode_e           line_mode = MODE_AXIS;
  logic signed [15:0] cur_col = '0, cur_row = '0, tgt_col = '0, tgt_row = '0;
  int                 span_col = 0, span_row = 0, bres_err = 0;
  bit                 neg_col = 1'b0, neg_row = 1'b0, col_major = 1'b0;
  int unsigned        slope = 0, frac = 0, steps_left = 0;

  function automatic void emit_pixel(logic signed [15:0] px, logic signed [15:0] py,
                                     logic [7:0] level, bit last, bit done);
    lr_out_t pix;
    pix.pixel_x      = px;
    pix.pixel_y      = py;
    pix.intensity    = level;
    pix.last_of_item = last;
    pix.line_done    = done;
    pending_pixels.push_back(pix);
  endfunction

  function automatic void rasterize(lr_in_t beat);
    int                 sx, sy, e2;
    int unsigned        major_span, minor_span, carry;
    logic [7:0]         weight;
    logic signed [15:0] nbr_col, nbr_row;
    if (beat.kind == KIND_LOAD) begin
      cur_col   = beat.start_x;
      cur_row   = beat.start_y;
      tgt_col   = beat.end_x;
      tgt_row   = beat.end_y;
      neg_col   = tgt_col < cur_col;
      neg_row   = tgt_row < cur_row;
      span_col  = neg_col ? int'(cur_col) - int'(tgt_col) : int'(tgt_col) - int'(cur_col);
      span_row  = neg_row ? int'(cur_row) - int'(tgt_row) : int'(tgt_row) - int'(cur_row);
      col_major = span_col > span_row;
      bres_err  = span_col - span_row;
      frac       = 0;
      slope      = 0;
      steps_left = 0;
      if (cur_col == tgt_col && cur_row == tgt_row) begin
        line_active = 1'b0;
        line_mode   = MODE_AXIS;
        emit_pixel(cur_col, cur_row, INTENSITY_FULL, 1'b1, 1'b1);
      end else begin
        line_active = 1'b1;
        if (cur_col == tgt_col || cur_row == tgt_row) begin
          line_mode = MODE_AXIS;
        end else if (aa_cfg) begin
          line_mode  = MODE_AA;
          major_span = col_major ? span_col : span_row;
          minor_span = col_major ? span_row : span_col;
          slope      = (minor_span << 16) / major_span;
          steps_left = major_span - 1;
        end else begin
          line_mode = MODE_MONO;
        end
        emit_pixel(cur_col, cur_row, INTENSITY_FULL, 1'b1, 1'b0);
      end
    end else if (line_active) begin
      sx = neg_col ? -1 : 1;
      sy = neg_row ? -1 : 1;
      if (line_mode == MODE_AA) begin
        if (steps_left == 0) begin
          line_active = 1'b0;
          emit_pixel(tgt_col, tgt_row, INTENSITY_FULL, 1'b1, 1'b1);
        end else begin
          frac  = frac + slope;
          carry = frac >> 16;
          frac  = frac & 32'hFFFF;
          if (col_major) begin
            cur_col = 16'(cur_col + sx);
            if (carry != 0) cur_row = 16'(cur_row + sy);
            nbr_col = cur_col;
            nbr_row = 16'(cur_row + sy);
          end else begin
            cur_row = 16'(cur_row + sy);
            if (carry != 0) cur_col = 16'(cur_col + sx);
            nbr_col = 16'(cur_col + sx);
            nbr_row = cur_row;
          end
          weight = frac[15:8];
          emit_pixel(cur_col, cur_row, ~weight, 1'b0, 1'b0);
          emit_pixel(nbr_col, nbr_row, weight, 1'b1, 1'b0);
          steps_left--;
        end
      end else begin
        if (line_mode == MODE_MONO) begin
          e2 = bres_err * 2;
          if (e2 > -span_row) begin
            bres_err -= span_row;
            cur_col = 16'(cur_col + sx);
          end
          if (e2 < span_col) begin
            bres_err += span_col;
            cur_row = 16'(cur_row + sy);
          end
        end else begin
          if (cur_col != tgt_col) cur_col = 16'(cur_col + sx);
          if (cur_row != tgt_row) cur_row = 16'(cur_row + sy);
        end
        if (cur_col == tgt_col && cur_row == tgt_row) begin
          line_active = 1'b0;
          emit_pixel(cur_col, cur_row, INTENSITY_FULL, 1'b1, 1'b1);
        end else begin
          emit_pixel(cur_col, cur_row, INTENSITY_FULL, 1'b1, 1'b0);
        end
      end
    end
  endfunction

  // Sender: bursts of beats with random gaps in between.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    bit     offer;
    lr_in_t next_beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      offer     = in_valid_i;
      next_beat = in_data_i;
      if (in_valid_i && in_ready_o) begin
        rasterize(in_data_i);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_beats.size() != 0) begin
          next_beat = queued_beats.pop_front();
          offer     = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid_i <= offer;
      in_data_i  <= next_beat;
    end
  end

  // Receiver: stall rate changes from window to window.
  int win_left = 0;
  int stall_pct = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (win_left == 0) begin
        win_left = $urandom_range(8, 80);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      win_left--;
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Long receiver hold-offs so that the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_valid_o && out_ready_i && (pixels_seen == 400 || pixels_seen == 1600)) begin
      hold_left <= 300;
    end
  end

  task automatic flag_pixel(string what, lr_out_t want, lr_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected (%0d,%0d) level %0d last %0b done %0b,",
               what, want.pixel_x, want.pixel_y, want.intensity, want.last_of_item,
               want.line_done);
      $display("  got (%0d,%0d) level %0d last %0b done %0b",
               got.pixel_x, got.pixel_y, got.intensity, got.last_of_item, got.line_done);
    end
  endtask

  always @(posedge clk_i) begin
    lr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen <= pixels_seen + 1;
      if (pending_pixels.size() == 0) begin
        flag_pixel("pixel beat with none expected", '0, out_data_o);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.pixel_x !== want.pixel_x || out_data_o.pixel_y !== want.pixel_y ||
            out_data_o.intensity !== want.intensity ||
            out_data_o.last_of_item !== want.last_of_item ||
            out_data_o.line_done !== want.line_done) begin
          flag_pixel("pixel mismatch", want, out_data_o);
        end
      end
    end
  end

  task automatic add_load(logic signed [15:0] x0, logic signed [15:0] y0,
                          logic signed [15:0] x1, logic signed [15:0] y1);
    lr_in_t beat;
    beat.kind    = KIND_LOAD;
    beat.start_x = x0;
    beat.start_y = y0;
    beat.end_x   = x1;
    beat.end_y   = y1;
    queued_beats.push_back(beat);
  endtask

  task automatic add_steps(int count);
    lr_in_t      beat;
    logic [95:0] noise;
    repeat (count) begin
      noise     = {$urandom, $urandom, $urandom};
      beat      = noise[$bits(lr_in_t)-1:0];
      beat.kind = KIND_STEP;
      queued_beats.push_back(beat);
    end
  endtask

  function automatic int line_len(logic signed [15:0] x0, logic signed [15:0] y0,
                                  logic signed [15:0] x1, logic signed [15:0] y1);
    int ax, ay;
    ax = int'(x1) - int'(x0);
    ay = int'(y1) - int'(y0);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return (ax > ay) ? ax : ay;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'(16'sh7FFF - $urandom_range(0, 15))
                                     : 16'(16'sh8000 + $urandom_range(0, 15));
      1: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    do @(posedge clk_i);
    while (queued_beats.size() != 0 || in_valid_i || pending_pixels.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_aa_cfg(bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    aa_cfg = value;
  endtask

  initial begin
    logic signed [15:0] x0, y0, x1, y1;
    int dx, dy, steps, phase_items;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_steps(1);
    add_load(0, 0, 0, 0);
    add_load(5, 3, 2, 3);
    add_steps(3);
    add_load(0, 0, 3, -3);
    add_steps(3);
    add_load(32767, -32768, 32764, -32766);
    add_steps(3);
    add_load(-32768, -32768, 32767, 32767);
    add_steps(2);
    add_load(0, 0, -5, 2);
    add_steps(2);
    drain();
    // The anti-aliased line is still open; it must finish in its own mode.
    write_aa_cfg(1'b0);
    add_steps(3);
    add_load(1, 1, 6, -2);
    add_steps(5);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_aa_cfg(p % 2 == 0);
      phase_items = 0;
      while (phase_items < 235) begin
        x0 = rand_coord();
        y0 = rand_coord();
        case ($urandom_range(0, 9))
          8: begin
            x1 = 16'($urandom);
            y1 = 16'($urandom);
            steps = $urandom_range(0, 4);
            add_load(x0, y0, x1, y1);
            add_steps(steps);
            phase_items += 1 + steps;
          end
          9: begin
            add_steps($urandom_range(1, 3));
          end
          default: begin
            dx = int'($urandom_range(0, 24)) - 12;
            dy = int'($urandom_range(0, 24)) - 12;
            case ($urandom_range(0, 7))
              0: dy = 0;
              1: dx = 0;
              2: dy = $urandom_range(0, 1) ? dx : -dx;
              3: if ($urandom_range(0, 2) == 0) begin
                dx = 0;
                dy = 0;
              end
              default: ;
            endcase
            x1 = 16'(x0 + dx);
            y1 = 16'(y0 + dy);
            steps = line_len(x0, y0, x1, y1);
            if (steps > 40) steps = $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
            add_load(x0, y0, x1, y1);
            add_steps(steps);
            phase_items += 1 + steps;
            if ($urandom_range(0, 9) == 0) add_steps($urandom_range(1, 2));
          end
        endcase
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("line_rasterizer regression: pass");
    end else begin
      $display("line_rasterizer regression: fail");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("line_rasterizer regression: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/lr_pkg.sv
rtl/lr_div.sv
rtl/lr_dpath.sv
rtl/lr_ctrl.sv
rtl/line_rasterizer.sv
dv/line_rasterizer_test.sv
